FILE: hdl/tth_pkg.sv
`timescale 1ns / 1ps

package tth_pkg;

	// table geometry
	localparam int MAX_BUCKETS  = 4096;
	localparam int PAYLOAD_BITS = 64;
	localparam int ADDR_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

	// field widths
	localparam int KEY_W     = 64;
	localparam int DEPTH_W   = 8;
	localparam int PAYLOAD_W = 64;
	localparam int CFG_W     = 13;

	// divisor width: holds any register value and the bucket limit itself
	localparam int NUM_W = $clog2(MAX_BUCKETS + 1);
	localparam int DIV_W = (CFG_W > NUM_W) ? CFG_W : NUM_W;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

	// command codes
	typedef enum logic [1:0] {
		ACT_STORE        = 2'd0,
		ACT_LOOKUP_ANY   = 2'd1,
		ACT_LOOKUP_EXACT = 2'd2,
		ACT_CLEAR        = 2'd3
	} action_t;

	typedef struct packed {
		action_t              action;
		logic [KEY_W-1:0]     key;
		logic [DEPTH_W-1:0]   depth;
		logic [PAYLOAD_W-1:0] payload;
	} cmd_t;

	typedef struct packed {
		logic                 hit;
		logic                 slot;
		logic [DEPTH_W-1:0]   found_depth;
		logic [PAYLOAD_W-1:0] found_payload;
	} res_t;

	// one slot as held in memory
	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [DEPTH_W-1:0]      depth;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

endpackage

FILE: hdl/tth_ram.sv
`timescale 1ns / 1ps

module tth_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/tth_mod.sv
`timescale 1ns / 1ps

module tth_mod
	import tth_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output logic [ADDR_W-1:0] rem
);

	localparam int CNT_W = $clog2(KEY_W);

	logic [KEY_W-1:0] key_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic [DIV_W-1:0] rem_next;

	// one restoring step: shift in the next key bit, subtract if it fits (no borrow)
	always_comb begin
		trial    = {rem_q, key_q[KEY_W-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
	end

	// step sequencer, msb first, one key bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			div_q  <= DIV_W'(1);
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				key_q <= key;
				div_q <= divisor;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= rem_next;
				key_q <= {key_q[KEY_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[ADDR_W-1:0];

	// remainder always below the divisor once finished
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	// finish follows the last running step, with run already dropped
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q) && !run_q)
		else $error("finish without a running division");

endmodule

FILE: hdl/two_tier_hash_table_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// command   in         start, busy (transfer: start & !busy)  cmd (cmd_t)
// result    out        done (one-cycle strobe)       result (res_t)
// config    in         cfg_valid, cfg_ready          cfg_data (bucket count)
//
// store and lookup: 64 bit-serial key modulo steps, then the remainder is registered
// as the bucket, one memory read and one evaluate step; a new transfer can be
// taken in the cycle that shows the done strobe.
// a clear command sweeps both slot memories one bucket per cycle, all MAX_BUCKETS
// buckets (4096), and strobes done in the cycle after the sweep. the same sweep
// runs after reset with busy high and no strobe. the receiver cannot stall;
// busy holds off new commands.

module two_tier_hash_table_unit
	import tth_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output res_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_EVAL
	} state_t;

	state_t            state_q;
	logic              done_q;
	res_t              result_q;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] bucket_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_reply_q;
	logic [CFG_W-1:0]  entries_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [ADDR_W-1:0] div_rem;
	logic [DIV_W-1:0]  divisor;

	logic              mem_we;
	logic              pref_we;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t            new_entry;
	entry_t            mem_wdata;
	logic              mem_re;
	entry_t            pref_rd;
	entry_t            recent_rd;

	logic              exact;
	logic              pref_match;
	logic              recent_match;
	res_t              lookup_res;

	assign accept    = start && (state_q == S_IDLE);
	assign div_start = accept && (cmd.action != ACT_CLEAR);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	// zero counts as one, large values saturate at the table size
	always_comb begin
		if (entries_q == '0) begin
			divisor = DIV_W'(1);
		end else if (DIV_W'(entries_q) > DIV_W'(MAX_BUCKETS)) begin
			divisor = DIV_W'(MAX_BUCKETS);
		end else begin
			divisor = DIV_W'(entries_q);
		end
	end

	tth_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.key     (cmd.key),
		.divisor (divisor),
		.done    (div_done),
		.rem     (div_rem)
	);

	// memory write side: clearing sweep or store update
	always_comb begin
		new_entry.key     = cmd_q.key;
		new_entry.depth   = cmd_q.depth;
		new_entry.payload = cmd_q.payload[PAYLOAD_BITS-1:0];
		mem_re            = (state_q == S_READ);
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			pref_we   = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == S_EVAL) && (cmd_q.action == ACT_STORE);
			pref_we   = mem_we && (cmd_q.depth > pref_rd.depth);
			mem_waddr = bucket_q;
			mem_wdata = new_entry;
		end
	end

	tth_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_BUCKETS)
	) u_pref_ram (
		.clk   (clk),
		.we    (pref_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (bucket_q),
		.rdata (pref_rd)
	);

	tth_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_BUCKETS)
	) u_recent_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (bucket_q),
		.rdata (recent_rd)
	);

	// lookup: depth-preferred slot first, then always-replace
	always_comb begin
		exact        = (cmd_q.action == ACT_LOOKUP_EXACT);
		pref_match   = (pref_rd.key == cmd_q.key) &&
			(!exact || (pref_rd.depth == cmd_q.depth));
		recent_match = (recent_rd.key == cmd_q.key) &&
			(!exact || (recent_rd.depth == cmd_q.depth));
		lookup_res   = '0;
		if (cmd_q.action == ACT_LOOKUP_ANY || cmd_q.action == ACT_LOOKUP_EXACT) begin
			if (pref_match) begin
				lookup_res.hit           = 1'b1;
				lookup_res.slot          = 1'b0;
				lookup_res.found_depth   = pref_rd.depth;
				lookup_res.found_payload = PAYLOAD_W'(pref_rd.payload);
			end else if (recent_match) begin
				lookup_res.hit           = 1'b1;
				lookup_res.slot          = 1'b1;
				lookup_res.found_depth   = recent_rd.depth;
				lookup_res.found_payload = PAYLOAD_W'(recent_rd.payload);
			end
		end
	end

	// sequencer with registered result and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			done_q      <= 1'b0;
			result_q    <= '0;
			cmd_q       <= '0;
			bucket_q    <= '0;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(MAX_BUCKETS - 1)) begin
						clr_addr_q  <= '0;
						done_q      <= clr_reply_q;
						result_q    <= '0;
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						if (cmd.action == ACT_CLEAR) begin
							clr_reply_q <= 1'b1;
							state_q     <= S_CLEAR;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						bucket_q <= div_rem;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					result_q <= lookup_res;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a transfer always makes the unit busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not start work");

	// a strobe only follows evaluation or a requested clear sweep
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EVAL) || ($past(state_q) == S_CLEAR))
		else $error("result strobe without finished work");

	// a miss or non-lookup reports all zeros
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |->
			(!result.slot && result.found_depth == '0 && result.found_payload == '0))
		else $error("miss result not zero");

	// memory writes only during the sweep or the evaluate step of a store
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR) ||
			(state_q == S_EVAL && cmd_q.action == ACT_STORE))
		else $error("memory written outside sweep or store");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tth_pkg::*;

	localparam int STALL_LIMIT     = 20000;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int PHASES          = 10;
	localparam int SETTLE_CYCLES   = 80;
	localparam int POOL_SIZE       = 24;

	// two-slot bucket store predictor with an in-order queue of expected results
	class tt_scoreboard;
		entry_t           deep_slot   [MAX_BUCKETS];
		entry_t           recent_slot [MAX_BUCKETS];
		logic [CFG_W-1:0] bucket_count;
		res_t             result_q [$];
		int               errors;

		function new();
			bucket_count = CFG_RESET;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (deep_slot[i]) begin
				deep_slot[i]   = '0;
				recent_slot[i] = '0;
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		// zero count acts as one, counts above the store size saturate
		function logic [ADDR_W-1:0] bucket_of(logic [KEY_W-1:0] k);
			logic [KEY_W-1:0] n;
			n = KEY_W'(bucket_count);
			if (n == 0)
				n = 1;
			if (n > MAX_BUCKETS)
				n = MAX_BUCKETS;
			return ADDR_W'(k % n);
		endfunction

		function void note_command(cmd_t c);
			res_t             r;
			entry_t           e;
			logic [ADDR_W-1:0] b;
			logic             exact;
			r = '0;
			b = bucket_of(c.key);
			exact = (c.action == ACT_LOOKUP_EXACT);
			case (c.action)
				ACT_STORE: begin
					e.key     = c.key;
					e.depth   = c.depth;
					e.payload = c.payload[PAYLOAD_BITS-1:0];
					recent_slot[b] = e;
					if (c.depth > deep_slot[b].depth)
						deep_slot[b] = e;
				end
				ACT_CLEAR: begin
					wipe();
				end
				default: begin
					// depth-preferred slot wins over the always-replace slot
					if (deep_slot[b].key == c.key &&
							(!exact || deep_slot[b].depth == c.depth)) begin
						r.hit           = 1'b1;
						r.slot          = 1'b0;
						r.found_depth   = deep_slot[b].depth;
						r.found_payload = PAYLOAD_W'(deep_slot[b].payload);
					end else if (recent_slot[b].key == c.key &&
							(!exact || recent_slot[b].depth == c.depth)) begin
						r.hit           = 1'b1;
						r.slot          = 1'b1;
						r.found_depth   = recent_slot[b].depth;
						r.found_payload = PAYLOAD_W'(recent_slot[b].payload);
					end
				end
			endcase
			result_q.push_back(r);
		endfunction

		function void compare(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: expected none, got %h",
					$time, got);
				return;
			end
			want = result_q.pop_front();
			compare("hit", 64'(want.hit), 64'(got.hit));
			compare("slot", 64'(want.slot), 64'(got.slot));
			compare("found_depth", 64'(want.found_depth), 64'(got.found_depth));
			compare("found_payload", want.found_payload, got.found_payload);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             done;
	res_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	tt_scoreboard     sb;
	logic [KEY_W-1:0] key_pool [$];
	logic [CFG_W-1:0] phase_cfg [PHASES];
	bit               quiet;
	int               stall;

	two_tier_hash_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// monitor: results, command transfers and the no-progress watchdog
	always @(posedge clk) begin
		if (done)
			sb.check_result(result);
		if (start && !busy)
			sb.note_command(cmd);
		if (done || (start && !busy) || (cfg_valid && cfg_ready))
			stall = 0;
		else
			stall++;
		if (stall == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// present one command and hold it until the transfer
	task automatic send_cmd(input cmd_t c);
		if (!quiet && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic issue(input action_t a, input logic [KEY_W-1:0] k,
			input logic [DEPTH_W-1:0] d, input logic [PAYLOAD_W-1:0] p);
		cmd_t c;
		c.action  = a;
		c.key     = k;
		c.depth   = d;
		c.payload = p;
		send_cmd(c);
	endtask

	// bucket count write, only once every expected result is in
	task automatic set_buckets(input logic [CFG_W-1:0] v);
		// wait for the clock first so the monitor has noted the last transfer
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		if (!quiet && $urandom_range(99) < 7)
			repeat ($urandom_range(1, 10)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.bucket_count = v;
	endtask

	function automatic int live_buckets(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_BUCKETS)
			return MAX_BUCKETS;
		return int'(v);
	endfunction

	// keys that collide in one bucket, small keys and wide random keys
	function automatic void refill_pool(int span);
		logic [KEY_W-1:0] base;
		base = {$urandom, $urandom};
		repeat (8) begin
			case ($urandom_range(2))
				0: key_pool.push_back({$urandom, $urandom});
				1: key_pool.push_back(KEY_W'($urandom_range(0, 20)));
				default: key_pool.push_back(base + KEY_W'($urandom_range(0, 3)) * KEY_W'(span));
			endcase
		end
		while (key_pool.size() > POOL_SIZE)
			void'(key_pool.pop_front());
	endfunction

	// mostly stores and lookups on pooled keys, some noise including clears
	function automatic cmd_t pick_cmd();
		cmd_t c;
		int   roll;
		roll      = $urandom_range(99);
		c.key     = key_pool[$urandom_range(key_pool.size() - 1)];
		c.depth   = ($urandom_range(3) == 0) ? DEPTH_W'($urandom) : DEPTH_W'($urandom_range(7));
		c.payload = {$urandom, $urandom};
		if (roll < 40)
			c.action = ACT_STORE;
		else if (roll < 65)
			c.action = ACT_LOOKUP_ANY;
		else if (roll < 88)
			c.action = ACT_LOOKUP_EXACT;
		else begin
			c.action = action_t'($urandom_range(3));
			c.key    = {$urandom, $urandom};
		end
		return c;
	endfunction

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		quiet = 1'b0;
		stall = 0;
		sb = new();
		phase_cfg = '{CFG_W'(0), CFG_W'(1), CFG_W'(8191), CFG_W'(4097), CFG_W'(3),
			CFG_W'($urandom_range(1, 64)), CFG_W'(2), CFG_W'($urandom_range(1, 4096)),
			CFG_W'(4096), CFG_W'(5)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty slots, replacement rules, exact depth, extremes, clear
		issue(ACT_LOOKUP_ANY, 64'h0, 8'h00, 64'h0);
		issue(ACT_LOOKUP_EXACT, 64'h0, 8'h00, 64'h0);
		issue(ACT_LOOKUP_EXACT, 64'h0, 8'h05, 64'h0);
		issue(ACT_STORE, 64'h123, 8'd10, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(ACT_LOOKUP_ANY, 64'h123, 8'd0, 64'h0);
		issue(ACT_STORE, 64'h1123, 8'd10, 64'hA5A5_5A5A_0F0F_F0F0);
		issue(ACT_LOOKUP_ANY, 64'h123, 8'd0, 64'h0);
		issue(ACT_LOOKUP_ANY, 64'h1123, 8'd0, 64'h0);
		issue(ACT_LOOKUP_EXACT, 64'h123, 8'd9, 64'h0);
		issue(ACT_LOOKUP_EXACT, 64'h1123, 8'd10, 64'h0);
		issue(ACT_STORE, 64'h2123, 8'd11, 64'h5A5A_A5A5_F0F0_0F0F);
		issue(ACT_LOOKUP_ANY, 64'h2123, 8'd0, 64'h0);
		issue(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 64'h0);
		issue(ACT_LOOKUP_EXACT, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 64'h0);
		issue(ACT_STORE, 64'h456, 8'd0, 64'h1);
		issue(ACT_LOOKUP_ANY, 64'h456, 8'd0, 64'h0);
		issue(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(ACT_LOOKUP_ANY, 64'h123, 8'd0, 64'h0);
		issue(ACT_LOOKUP_ANY, 64'h0, 8'd0, 64'h0);
		start <= 1'b0;

		// random phases over a range of bucket counts, table kept across writes
		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == 3);
			set_buckets(phase_cfg[p]);
			refill_pool(live_buckets(phase_cfg[p]));
			repeat (ITEMS_PER_PHASE)
				send_cmd(pick_cmd());
			start <= 1'b0;
		end

		// wait for the clock first so the monitor has noted the last transfer
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
